// ===== hw/rtl/ccc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, codes and calendar helpers for the calendar clock counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

	localparam int unsigned YearW   = 14;
	localparam int unsigned MonthW  = 4;
	localparam int unsigned DayW    = 5;
	localparam int unsigned HourW   = 5;
	localparam int unsigned MinuteW = 6;
	localparam int unsigned SecondW = 6;

	localparam logic [YearW-1:0]   YearMax   = YearW'(9999);
	localparam logic [MonthW-1:0]  MonthMax  = MonthW'(12);
	localparam logic [MonthW-1:0]  MonthMin  = MonthW'(1);
	localparam logic [DayW-1:0]    DayMin    = DayW'(1);
	localparam logic [HourW-1:0]   HourMax   = HourW'(23);
	localparam logic [MinuteW-1:0] MinuteMax = MinuteW'(59);
	localparam logic [SecondW-1:0] SecondMax = SecondW'(59);

	localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
	localparam logic [MonthW-1:0] MonthApr = MonthW'(4);
	localparam logic [MonthW-1:0] MonthJun = MonthW'(6);
	localparam logic [MonthW-1:0] MonthSep = MonthW'(9);
	localparam logic [MonthW-1:0] MonthNov = MonthW'(11);

	// Operation codes carried by the op field of an input beat.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef struct packed {
		logic [YearW-1:0]   year;
		logic [MonthW-1:0]  month;
		logic [DayW-1:0]    day;
		logic [HourW-1:0]   hour;
		logic [MinuteW-1:0] minute;
		logic [SecondW-1:0] second;
	} ccc_time_t;

	// Request handed to the next-state logic for one accepted beat.
	typedef struct packed {
		logic      op;
		ccc_time_t load;
	} ccc_req_t;

	// Length of a month; leap years are those whose number is a multiple of four.
	function automatic logic [DayW-1:0] days_in_month(
		input logic [MonthW-1:0] month,
		input logic [YearW-1:0]  year
	);
		logic [DayW-1:0] len;
		case (month) inside
			MonthFeb: len = (year[1:0] == 2'b00) ? DayW'(29) : DayW'(28);
			MonthApr, MonthJun, MonthSep, MonthNov: len = DayW'(30);
			default: len = DayW'(31);
		endcase
		return len;
	endfunction

endpackage

// ===== hw/rtl/ccc_next.sv =====
// ----------------------------------------------------------------------------
// ccc_next
// Next-state logic: one-second cascade or a checked load of date and time.
// ----------------------------------------------------------------------------
module ccc_next
	import ccc_pkg::*;
(
	input  ccc_time_t cur,
	input  ccc_req_t  req,
	output ccc_time_t nxt,
	output logic      rejected
);

	ccc_time_t       ticked;
	logic            sec_wrap;
	logic            min_wrap;
	logic            hour_wrap;
	logic            day_wrap;
	logic            month_wrap;
	logic            load_ok;
	logic [DayW-1:0] load_len;

	// Each wrap feeds the carry of the next counter up the chain.
	always_comb begin
		sec_wrap   = (cur.second == SecondMax);
		min_wrap   = sec_wrap && (cur.minute == MinuteMax);
		hour_wrap  = min_wrap && (cur.hour == HourMax);
		day_wrap   = hour_wrap && (cur.day == days_in_month(cur.month, cur.year));
		month_wrap = day_wrap && (cur.month == MonthMax);

		ticked = cur;
		ticked.second = sec_wrap ? '0 : cur.second + SecondW'(1);
		if (sec_wrap) begin
			ticked.minute = min_wrap ? '0 : cur.minute + MinuteW'(1);
		end
		if (min_wrap) begin
			ticked.hour = hour_wrap ? '0 : cur.hour + HourW'(1);
		end
		if (hour_wrap) begin
			ticked.day = day_wrap ? DayMin : cur.day + DayW'(1);
		end
		if (day_wrap) begin
			ticked.month = month_wrap ? MonthMin : cur.month + MonthW'(1);
		end
		if (month_wrap) begin
			ticked.year = (cur.year >= YearMax) ? '0 : cur.year + YearW'(1);
		end
	end

	always_comb begin
		load_len = days_in_month(req.load.month, req.load.year);
		load_ok  = (req.load.year <= YearMax) &&
		           (req.load.month >= MonthMin) && (req.load.month <= MonthMax) &&
		           (req.load.hour <= HourMax) &&
		           (req.load.minute <= MinuteMax) &&
		           (req.load.second <= SecondMax) &&
		           (req.load.day >= DayMin) && (req.load.day <= load_len);

		if (req.op == OP_TICK) begin
			nxt      = ticked;
			rejected = 1'b0;
		end else begin
			nxt      = load_ok ? req.load : cur;
			rejected = !load_ok;
		end
	end

endmodule

// ===== hw/rtl/calendar_clock_counter_unit.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_counter_unit
// Real-time clock and calendar counter with tick and load operations.
// ----------------------------------------------------------------------------
// Usage
// The input channel (in_valid / in_ready) carries one beat per operation. With
// op at tick the clock advances one second, rippling through minutes, hours,
// day of month, month and year; the year wraps from 9999 to 0. With op at load
// the date and time fields are checked and, if all are in range, replace the
// counters. An out-of-range load leaves the counters alone and is flagged.
// The output channel (out_valid / out_ready) returns exactly one beat for each
// input beat: the date and time after the operation and load_rejected.
// The result of a beat is registered and shown in the cycle after acceptance.
// Throughput is one beat per cycle while out_ready is high; the single counter
// register bank, updated by one level of cascade logic, sets that rate.
// The counter registers double as the output register. A new beat is taken
// whenever the output is empty or being drained in the same cycle, so with
// out_ready held high beats flow back to back. While the receiver stalls, the
// pending result holds and in_ready stays low.
// Reset clears the clock to 00:00:00 on day 1 of month 1, year 0, and empties
// the output.
// ----------------------------------------------------------------------------
module calendar_clock_counter_unit
	import ccc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [YearW-1:0]   load_year,
	input  logic [MonthW-1:0]  load_month,
	input  logic [DayW-1:0]    load_day,
	input  logic [HourW-1:0]   load_hour,
	input  logic [MinuteW-1:0] load_minute,
	input  logic [SecondW-1:0] load_second,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SecondW-1:0] cur_second,
	output logic [MinuteW-1:0] cur_minute,
	output logic [HourW-1:0]   cur_hour,
	output logic [DayW-1:0]    cur_day,
	output logic [MonthW-1:0]  cur_month,
	output logic [YearW-1:0]   cur_year,
	output logic               load_rejected
);

	ccc_time_t time_q;
	ccc_time_t time_nxt;
	ccc_req_t  req;
	logic      rejected_nxt;
	logic      rejected_q;
	logic      out_valid_q;
	logic      in_fire;

	// A beat may enter when the result slot is empty or is drained this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		req.op          = op;
		req.load.year   = load_year;
		req.load.month  = load_month;
		req.load.day    = load_day;
		req.load.hour   = load_hour;
		req.load.minute = load_minute;
		req.load.second = load_second;
	end

	ccc_next u_next (
		.cur      (time_q),
		.req      (req),
		.nxt      (time_nxt),
		.rejected (rejected_nxt)
	);

	// The clock counters are architectural state and also the visible result,
	// so they change only on an accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q.year   <= '0;
			time_q.month  <= MonthMin;
			time_q.day    <= DayMin;
			time_q.hour   <= '0;
			time_q.minute <= '0;
			time_q.second <= '0;
			rejected_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				time_q     <= time_nxt;
				rejected_q <= rejected_nxt;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign cur_second    = time_q.second;
	assign cur_minute    = time_q.minute;
	assign cur_hour      = time_q.hour;
	assign cur_day       = time_q.day;
	assign cur_month     = time_q.month;
	assign cur_year      = time_q.year;
	assign load_rejected = rejected_q;

	// A tick never raises the rejection flag.
	a_tick_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_TICK) |=> !load_rejected)
		else $error("tick produced a rejected result");

	// A rejected load leaves the clock untouched.
	a_reject_holds_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_LOAD && rejected_nxt) |=> $stable(time_q))
		else $error("rejected load changed the clock");

	// The counters never leave their legal ranges.
	a_time_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(time_q.second <= SecondMax) && (time_q.minute <= MinuteMax) &&
		(time_q.hour <= HourMax) && (time_q.day >= DayMin) &&
		(time_q.day <= days_in_month(time_q.month, time_q.year)) &&
		(time_q.month >= MonthMin) && (time_q.month <= MonthMax) &&
		(time_q.year <= YearMax))
		else $error("clock counter out of range");

	// The clock moves only when a beat is accepted.
	a_time_moves_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(time_q))
		else $error("clock changed without an accepted beat");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the calendar clock counter. Tick and load beats are
// queued up front, driven on falling edges with random gaps, and each result
// beat is checked field by field against a software calendar kept in step.
// ----------------------------------------------------------------------------
module tb_top
	import ccc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// One result beat as the checker sees it: the clock after the step plus the flag.
	typedef struct packed {
		ccc_time_t stamp;
		logic      rejected;
	} clock_reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = OP_TICK;
	logic [YearW-1:0]   load_year = '0;
	logic [MonthW-1:0]  load_month = '0;
	logic [DayW-1:0]    load_day = '0;
	logic [HourW-1:0]   load_hour = '0;
	logic [MinuteW-1:0] load_minute = '0;
	logic [SecondW-1:0] load_second = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [SecondW-1:0] cur_second;
	logic [MinuteW-1:0] cur_minute;
	logic [HourW-1:0]   cur_hour;
	logic [DayW-1:0]    cur_day;
	logic [MonthW-1:0]  cur_month;
	logic [YearW-1:0]   cur_year;
	logic               load_rejected;

	// Operations waiting to be offered, and readings owed by the block, oldest first.
	ccc_req_t       pending_ops[$];
	clock_reading_t expected_readings[$];

	// The bench's own copy of the clock; it starts from the reset value.
	ccc_time_t wall_clock = '{year: '0, month: MonthMin, day: DayMin,
		hour: '0, minute: '0, second: '0};

	int unsigned fault_count = 0;
	int unsigned issued_count = 0;
	bit          beat_taken = 1'b0;

	calendar_clock_counter_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.load_year    (load_year),
		.load_month   (load_month),
		.load_day     (load_day),
		.load_hour    (load_hour),
		.load_minute  (load_minute),
		.load_second  (load_second),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cur_second   (cur_second),
		.cur_minute   (cur_minute),
		.cur_hour     (cur_hour),
		.cur_day      (cur_day),
		.cur_month    (cur_month),
		.cur_year     (cur_year),
		.load_rejected(load_rejected)
	);

	// 12 ns clock, low half first.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Days in a month under the simple leap rule: every fourth year has 29 February days.
	function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] month,
		input logic [YearW-1:0] year);
		if (month == MonthFeb) begin
			return (year % 4 == 0) ? DayW'(29) : DayW'(28);
		end
		if (month == MonthApr || month == MonthJun || month == MonthSep || month == MonthNov) begin
			return DayW'(30);
		end
		return DayW'(31);
	endfunction

	// Applies one accepted beat to the bench's clock and returns the reading it should produce.
	// A tick ripples up the cascade one unit at a time; since the counters only ever
	// hold legal values, comparing against the top of each range is enough to detect a carry.
	function automatic clock_reading_t advance_calendar(input ccc_req_t beat);
		clock_reading_t reading;
		ccc_time_t      c;
		logic           fits;
		c = wall_clock;
		reading.rejected = 1'b0;
		if (beat.op == OP_TICK) begin
			if (c.second != SecondMax) begin
				c.second += 1'b1;
			end else begin
				c.second = '0;
				if (c.minute != MinuteMax) begin
					c.minute += 1'b1;
				end else begin
					c.minute = '0;
					if (c.hour != HourMax) begin
						c.hour += 1'b1;
					end else begin
						c.hour = '0;
						if (c.day != month_length(c.month, c.year)) begin
							c.day += 1'b1;
						end else begin
							c.day = DayMin;
							if (c.month != MonthMax) begin
								c.month += 1'b1;
							end else begin
								c.month = MonthMin;
								c.year = (c.year >= YearMax) ? '0 : c.year + 1'b1;
							end
						end
					end
				end
			end
		end else begin
			// A load is all or nothing: one bad field, day and month zero included,
			// leaves the clock untouched and raises the flag.
			fits = beat.load.year <= YearMax && beat.load.month >= MonthMin &&
				beat.load.month <= MonthMax && beat.load.day >= DayMin &&
				beat.load.hour <= HourMax && beat.load.minute <= MinuteMax &&
				beat.load.second <= SecondMax;
			if (fits && beat.load.day > month_length(beat.load.month, beat.load.year)) begin
				fits = 1'b0;
			end
			if (fits) begin
				c = beat.load;
			end else begin
				reading.rejected = 1'b1;
			end
		end
		wall_clock = c;
		reading.stamp = c;
		return reading;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			fault_count++;
			if (fault_count <= 10) begin
				$display("mismatch on %s at %0t ns: expected %0d, got %0d",
					name, $time, want, got);
			end
		end
	endtask

	// Raw random bits in every field, legal or not.
	function automatic ccc_time_t random_bits();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(ccc_time_t)-1:0];
	endfunction

	// A legal date and time, usually parked just short of a carry so that a few
	// ticks afterwards roll minutes, hours, days, months or the year over.
	function automatic ccc_time_t edge_stamp();
		ccc_time_t t;
		case ($urandom_range(0, 4))
			0: t.year = YearMax;
			1: t.year = '0;
			2: t.year = YearW'($urandom_range(0, 24));
			default: t.year = YearW'($urandom_range(0, 9999));
		endcase
		t.month = ($urandom_range(0, 2) == 0) ? MonthMax : MonthW'($urandom_range(1, 12));
		t.day = $urandom_range(0, 1) ? month_length(t.month, t.year) :
			DayW'($urandom_range(1, month_length(t.month, t.year)));
		t.hour = ($urandom_range(0, 2) != 0) ? HourMax : HourW'($urandom_range(0, 23));
		t.minute = ($urandom_range(0, 2) != 0) ? MinuteMax : MinuteW'($urandom_range(0, 59));
		t.second = ($urandom_range(0, 2) != 0) ? SecondMax - SecondW'($urandom_range(0, 3)) :
			SecondW'($urandom_range(0, 59));
		return t;
	endfunction

	function automatic void queue_tick();
		pending_ops.push_back('{op: OP_TICK, load: random_bits()});
	endfunction

	function automatic void queue_load(input int unsigned year, input int unsigned month,
		input int unsigned day, input int unsigned hour, input int unsigned minute,
		input int unsigned second);
		ccc_req_t beat;
		beat.op = OP_LOAD;
		beat.load.year = YearW'(year);
		beat.load.month = MonthW'(month);
		beat.load.day = DayW'(day);
		beat.load.hour = HourW'(hour);
		beat.load.minute = MinuteW'(minute);
		beat.load.second = SecondW'(second);
		pending_ops.push_back(beat);
	endfunction

	// Driver. Inputs move only on falling edges. A new beat is offered once the
	// previous one has been taken; valid and payload then hold until the handshake.
	// Roughly 100 beats in the middle of the run go through with neither side idling.
	always @(negedge clk) begin
		logic     calm;
		logic     show;
		ccc_req_t beat;
		calm = issued_count >= 160 && issued_count < 260;
		if (arst_n) begin
			if (!in_valid || beat_taken) begin
				show = 1'b0;
				if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
					beat = pending_ops.pop_front();
					show = 1'b1;
					issued_count++;
					op <= beat.op;
					load_year <= beat.load.year;
					load_month <= beat.load.month;
					load_day <= beat.load.day;
					load_hour <= beat.load.hour;
					load_minute <= beat.load.minute;
					load_second <= beat.load.second;
				end
				in_valid <= show;
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 29);
		end
	end

	// Monitor. On each rising edge a result beat is checked against the oldest
	// expectation first, then an accepted input beat is run through the bench's
	// calendar and its reading queued. The check comes first so that a result
	// arriving with nothing owed is caught even if a new beat enters at that edge.
	always @(posedge clk) begin
		clock_reading_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("result beat at %0t ns with no result expected", $time);
					end
				end else begin
					want = expected_readings.pop_front();
					check_field("cur_second", want.stamp.second, cur_second);
					check_field("cur_minute", want.stamp.minute, cur_minute);
					check_field("cur_hour", want.stamp.hour, cur_hour);
					check_field("cur_day", want.stamp.day, cur_day);
					check_field("cur_month", want.stamp.month, cur_month);
					check_field("cur_year", want.stamp.year, cur_year);
					check_field("load_rejected", want.rejected, load_rejected);
				end
			end
			beat_taken = in_valid && in_ready;
			if (beat_taken) begin
				expected_readings.push_back(advance_calendar('{op: op, load: '{year: load_year,
					month: load_month, day: load_day, hour: load_hour,
					minute: load_minute, second: load_second}}));
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned pick;
		ccc_time_t   broken;

		// Directed part: first tick out of reset, then the year rollover from the
		// last second of 9999, all-ones and all-zero loads, day zero, the smallest
		// legal load, leap and non-leap February ends, a 30-day month end, and one
		// out-of-range value in each field in turn.
		queue_tick();
		queue_load(9999, 12, 31, 23, 59, 59);
		queue_tick();
		queue_load(16383, 15, 31, 31, 63, 63);
		queue_load(0, 0, 0, 0, 0, 0);
		queue_load(0, 1, 0, 0, 0, 0);
		queue_load(0, 1, 1, 0, 0, 0);
		queue_load(4, 2, 29, 23, 59, 59);
		queue_tick();
		queue_load(5, 2, 29, 0, 0, 0);
		queue_load(3, 2, 28, 23, 59, 59);
		queue_tick();
		queue_load(8, 2, 28, 23, 59, 59);
		queue_tick();
		queue_load(1, 4, 31, 0, 0, 0);
		queue_load(1, 4, 30, 23, 59, 59);
		queue_tick();
		queue_load(10000, 1, 1, 0, 0, 0);
		queue_load(2, 3, 15, 24, 0, 0);
		queue_load(2, 3, 15, 10, 60, 0);
		queue_load(2, 3, 15, 10, 20, 60);
		queue_load(2, 13, 15, 10, 20, 30);
		queue_load(7, 6, 30, 12, 59, 59);
		queue_tick();

		// Random part. Most of it is a legal load near a carry followed by a short
		// run of ticks; the rest is longer tick runs, loads with one field broken,
		// and loads of raw random bits.
		while (pending_ops.size() < 450) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				pending_ops.push_back('{op: OP_LOAD, load: edge_stamp()});
				repeat ($urandom_range(1, 6)) queue_tick();
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 20)) queue_tick();
			end else if (pick < 85) begin
				broken = edge_stamp();
				case ($urandom_range(0, 5))
					0: broken.year = YearW'($urandom_range(10000, 16383));
					1: broken.month = $urandom_range(0, 1) ? '0 : MonthW'($urandom_range(13, 15));
					2: begin
						if (month_length(broken.month, broken.year) == DayW'(31) ||
							$urandom_range(0, 1)) begin
							broken.day = '0;
						end else begin
							broken.day = DayW'($urandom_range(
								month_length(broken.month, broken.year) + 1, 31));
						end
					end
					3: broken.hour = HourW'($urandom_range(24, 31));
					4: broken.minute = MinuteW'($urandom_range(60, 63));
					default: broken.second = SecondW'($urandom_range(60, 63));
				endcase
				pending_ops.push_back('{op: OP_LOAD, load: broken});
			end else begin
				pending_ops.push_back('{op: OP_LOAD, load: random_bits()});
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every beat offered and taken, and every result back.
		while (pending_ops.size() != 0 || in_valid || expected_readings.size() != 0) begin
			@(posedge clk);
		end
		// The block registers its answer to each beat; spare edges afterwards catch strays.
		repeat (5) @(posedge clk);

		if (fault_count == 0) begin
			$display("PASS calendar_clock_counter_unit");
		end else begin
			$display("FAIL calendar_clock_counter_unit");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("FAIL calendar_clock_counter_unit");
		$finish;
	end

endmodule

// ===== calendar_clock_counter_unit.f =====
hw/rtl/ccc_pkg.sv
hw/rtl/ccc_next.sv
hw/rtl/calendar_clock_counter_unit.sv
tb/tb_top.sv
